/* rtl/lltm_pkg.sv */
// Shared types and codes for the linked list table manager.
`default_nettype none
package lltm_pkg;
	typedef enum logic [2:0] {
		MODE_OPEN  = 3'd0,
		MODE_CLOSE = 3'd1,
		MODE_PUSHF = 3'd2,
		MODE_PUSHB = 3'd3,
		MODE_POPF  = 3'd4,
		MODE_POPB  = 3'd5,
		MODE_RSVD6 = 3'd6,
		MODE_RSVD7 = 3'd7
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NO_FREE = 2'd1,
		ST_EMPTY   = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DESC,
		S_RD_H,
		S_RD_T,
		S_WALK,
		S_WR,
		S_WR2,
		S_INIT
	} state_t;
endpackage
`default_nettype wire

/* rtl/lltm_ram.sv */
// Single-port synchronous RAM with a registered read.
`default_nettype none
module lltm_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

/* rtl/linked_list_table_manager.sv */
// Top level: list descriptors, free list and the walking sequencer.
//
// Usage: raise start with mode, list_id, entry_value and entry_size while
// busy is low; the command is taken on that edge. One result comes back per
// command, shown for one cycle with done high: status, popped_value,
// popped_size, list_length and occupied_count. The receiver cannot stall it.
// Steps: every command is decided in S_DESC; ignored or rejected commands,
// close and a push onto an empty list finish there; open, push front, pop
// front and a pop from a one-entry list finish in S_RD_H or S_RD_T; push
// back goes on to S_WR; pop back of more entries walks the link RAM one entry
// per cycle from S_RD_T through S_WALK, then writes in S_WR and S_WR2. busy
// falls together with done rising, so the next command can be taken at the
// edge that ends the done cycle; one command is in flight at a time.
// The link, word and size tables sit in single-port RAMs with registered reads.
// After reset the link RAM is rebuilt to the chain 1,2,...,last,0, one entry
// per cycle with busy high. Descriptors (head, tail, count, open) are
// registers cleared by reset.
`default_nettype none
module linked_list_table_manager #(
	parameter int TABLE_ENTRIES = 256,
	parameter int LIST_SLOTS    = 16,
	parameter int WORD_BITS     = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [2:0]  mode,
	input  wire logic [3:0]  list_id,
	input  wire logic [31:0] entry_value,
	input  wire logic [15:0] entry_size,
	output logic             done,
	output logic [1:0]       status,
	output logic [31:0]      popped_value,
	output logic [15:0]      popped_size,
	output logic [7:0]       list_length,
	output logic [7:0]       occupied_count
);
	localparam int AW = $clog2(TABLE_ENTRIES);
	localparam int SW = (LIST_SLOTS > 1) ? $clog2(LIST_SLOTS) : 1;
	localparam int CW = AW + 1;
	localparam logic [AW-1:0] LAST = AW'(TABLE_ENTRIES - 1);

	lltm_pkg::state_t state_q, state_d;

	logic [AW-1:0] head_q [LIST_SLOTS];
	logic [AW-1:0] tail_q [LIST_SLOTS];
	logic [CW-1:0] cnt_q  [LIST_SLOTS];
	logic [LIST_SLOTS-1:0] open_q;
	logic [AW-1:0] free_q;
	logic [CW-1:0] used_q;

	lltm_pkg::mode_t mode_q;
	logic [SW-1:0]   id_q;
	logic            id_ok_q;
	logic [WORD_BITS-1:0] val_q;
	logic [15:0]     size_q;
	logic [AW-1:0]   ptr_q;
	logic [CW-1:0]   k_q;
	logic [WORD_BITS-1:0] pv_q;
	logic [15:0]     ps_q;

	logic            nx_we, pw_we;
	logic [AW-1:0]   nx_addr, nx_wd, nx_rd, pw_addr;
	logic [WORD_BITS-1:0] pw_rd;
	logic [15:0]     ps_rd;

	lltm_ram #(.DEPTH(TABLE_ENTRIES), .WIDTH(AW)) u_next (
		.clk(clk), .we(nx_we), .addr(nx_addr), .wdata(nx_wd), .rdata(nx_rd));
	lltm_ram #(.DEPTH(TABLE_ENTRIES), .WIDTH(WORD_BITS)) u_word (
		.clk(clk), .we(pw_we), .addr(pw_addr), .wdata(val_q), .rdata(pw_rd));
	lltm_ram #(.DEPTH(TABLE_ENTRIES), .WIDTH(16)) u_size (
		.clk(clk), .we(pw_we), .addr(pw_addr), .wdata(size_q), .rdata(ps_rd));

	logic [AW-1:0] h, t;
	logic [CW-1:0] n;
	logic          op, has_free, is_pop;
	assign h = head_q[id_q];
	assign t = tail_q[id_q];
	assign n = cnt_q[id_q];
	assign op = open_q[id_q];
	assign has_free = (used_q + CW'(1)) < CW'(TABLE_ENTRIES);
	assign is_pop  = (mode_q == lltm_pkg::MODE_POPF) || (mode_q == lltm_pkg::MODE_POPB);

	// Control: S_DESC decides from the descriptor, later states finish the RAM work.
	logic [1:0] st_d;
	logic       fin;
	logic       walk;
	always_comb begin
		state_d = state_q;
		nx_we = 1'b0;
		nx_addr = ptr_q;
		nx_wd = '0;
		pw_we = 1'b0;
		pw_addr = h;
		fin = 1'b0;
		walk = 1'b0;
		st_d = lltm_pkg::ST_OK;
		case (state_q)
			lltm_pkg::S_INIT: begin
				nx_we = 1'b1;
				nx_wd = (ptr_q == LAST) ? '0 : ptr_q + AW'(1);
				if (ptr_q == LAST) state_d = lltm_pkg::S_IDLE;
			end
			lltm_pkg::S_IDLE: begin
				if (start) state_d = lltm_pkg::S_DESC;
			end
			lltm_pkg::S_DESC: begin
				fin = 1'b1;
				state_d = lltm_pkg::S_IDLE;
				if (id_ok_q) begin
					case (mode_q)
						lltm_pkg::MODE_OPEN: if (!op) begin
							if (!has_free) st_d = lltm_pkg::ST_NO_FREE;
							else begin
								fin = 1'b0;
								nx_addr = free_q; // read next free
								state_d = lltm_pkg::S_RD_H;
							end
						end
						lltm_pkg::MODE_CLOSE: if (op) begin
							// splice the whole chain onto the free list
							nx_we = 1'b1;
							nx_addr = t;
							nx_wd = free_q;
						end
						lltm_pkg::MODE_PUSHF, lltm_pkg::MODE_PUSHB: begin
							if (!op) st_d = lltm_pkg::ST_NO_FREE;
							else if (n == '0) begin
								pw_we = 1'b1;
								pw_addr = h;
							end else if (!has_free) st_d = lltm_pkg::ST_NO_FREE;
							else begin
								fin = 1'b0;
								pw_we = 1'b1;
								pw_addr = free_q;
								nx_addr = free_q;
								state_d = lltm_pkg::S_RD_H;
							end
						end
						lltm_pkg::MODE_POPF, lltm_pkg::MODE_POPB: begin
							if (!op || n == '0) st_d = lltm_pkg::ST_EMPTY;
							else begin
								fin = 1'b0;
								pw_addr = (mode_q == lltm_pkg::MODE_POPB) ? t : h;
								nx_addr = h;
								state_d = lltm_pkg::S_RD_T;
							end
						end
						default: ;
					endcase
				end
			end
			lltm_pkg::S_RD_H: begin
				// nx_rd holds the link of the taken free entry
				nx_we = 1'b1;
				nx_addr = free_q;
				nx_wd = (mode_q == lltm_pkg::MODE_PUSHF) ? h : '0;
				if (mode_q == lltm_pkg::MODE_PUSHB) state_d = lltm_pkg::S_WR;
				else begin
					fin = 1'b1;
					state_d = lltm_pkg::S_IDLE;
				end
			end
			lltm_pkg::S_RD_T: begin
				if (mode_q == lltm_pkg::MODE_POPB && n > CW'(2)) walk = 1'b1;
				else if (mode_q == lltm_pkg::MODE_POPB && n == CW'(2))
					state_d = lltm_pkg::S_WR;
				else begin
					fin = 1'b1;
					state_d = lltm_pkg::S_IDLE;
					if (n != CW'(1)) begin
						nx_we = 1'b1;
						nx_addr = h;
						nx_wd = free_q;
					end
				end
			end
			lltm_pkg::S_WALK: begin
				walk = 1'b1;
			end
			lltm_pkg::S_WR: begin
				nx_we = 1'b1;
				nx_addr = t;
				if (mode_q == lltm_pkg::MODE_PUSHB) begin
					nx_wd = ptr_q;
					fin = 1'b1;
					state_d = lltm_pkg::S_IDLE;
				end else begin
					nx_wd = free_q;
					state_d = lltm_pkg::S_WR2;
				end
			end
			lltm_pkg::S_WR2: begin
				// cut the list after the new tail
				nx_we = 1'b1;
				nx_addr = ptr_q;
				nx_wd = '0;
				fin = 1'b1;
				state_d = lltm_pkg::S_IDLE;
			end
			default: state_d = lltm_pkg::S_IDLE;
		endcase
		// advance one link toward the predecessor of the tail
		if (walk) begin
			nx_addr = nx_rd;
			state_d = (k_q + CW'(3) < n) ? lltm_pkg::S_WALK : lltm_pkg::S_WR;
		end
	end

	assign busy = (state_q != lltm_pkg::S_IDLE);

	logic [WORD_BITS-1:0] pv_sel;
	logic [15:0]          ps_sel;
	assign pv_sel = (state_q == lltm_pkg::S_RD_T) ? pw_rd : pv_q;
	assign ps_sel = (state_q == lltm_pkg::S_RD_T) ? ps_rd : ps_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lltm_pkg::S_INIT;
			ptr_q   <= '0;
			k_q     <= '0;
			pv_q    <= '0;
			ps_q    <= '0;
			open_q  <= '0;
			free_q  <= AW'(1);
			used_q  <= '0;
			done    <= 1'b0;
			status  <= '0;
			popped_value <= '0;
			popped_size  <= '0;
			for (int i = 0; i < LIST_SLOTS; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				cnt_q[i]  <= '0;
			end
		end else begin
			state_q <= state_d;
			done <= fin;
			if (fin) begin
				status <= st_d;
				if (is_pop && st_d == lltm_pkg::ST_OK) begin
					popped_value <= 32'(pv_sel);
					popped_size  <= ps_sel;
				end else begin
					popped_value <= '0;
					popped_size  <= '0;
				end
			end
			if (walk) begin
				ptr_q <= nx_rd;
				k_q <= k_q + CW'(1);
			end
			case (state_q)
				lltm_pkg::S_INIT: ptr_q <= ptr_q + AW'(1);
				lltm_pkg::S_DESC: begin
					ptr_q <= h;
					k_q <= '0;
					if (id_ok_q && op) begin
						if (mode_q == lltm_pkg::MODE_CLOSE) begin
							free_q <= h;
							used_q <= used_q - ((n == '0) ? CW'(1) : n);
							cnt_q[id_q] <= '0;
							open_q[id_q] <= 1'b0;
						end else if ((mode_q == lltm_pkg::MODE_PUSHF ||
								mode_q == lltm_pkg::MODE_PUSHB) && n == '0) begin
							cnt_q[id_q] <= CW'(1);
						end
					end
				end
				lltm_pkg::S_RD_H: begin
					free_q <= nx_rd; // unlink free head
					ptr_q <= free_q;
					if (mode_q == lltm_pkg::MODE_OPEN) begin
						head_q[id_q] <= free_q;
						tail_q[id_q] <= free_q;
						cnt_q[id_q] <= '0;
						open_q[id_q] <= 1'b1;
						used_q <= used_q + CW'(1);
					end else if (mode_q == lltm_pkg::MODE_PUSHF) begin
						head_q[id_q] <= free_q;
						cnt_q[id_q] <= n + CW'(1);
						used_q <= used_q + CW'(1);
					end
				end
				lltm_pkg::S_RD_T: begin
					pv_q <= pw_rd;
					ps_q <= ps_rd;
					if (!(mode_q == lltm_pkg::MODE_POPB && n > CW'(1))) begin
						cnt_q[id_q] <= n - CW'(1);
						if (n != CW'(1)) begin
							used_q <= used_q - CW'(1);
							free_q <= h;
							head_q[id_q] <= nx_rd;
						end
					end
				end
				lltm_pkg::S_WR: begin
					if (mode_q == lltm_pkg::MODE_PUSHB) begin
						tail_q[id_q] <= ptr_q;
						cnt_q[id_q] <= n + CW'(1);
						used_q <= used_q + CW'(1);
					end
				end
				lltm_pkg::S_WR2: begin
					free_q <= t;
					tail_q[id_q] <= ptr_q;
					cnt_q[id_q] <= n - CW'(1);
					used_q <= used_q - CW'(1);
				end
				default: ;
			endcase
		end
	end

	// Command registers.
	always_ff @(posedge clk) begin
		if (state_q == lltm_pkg::S_IDLE && start) begin
			mode_q  <= lltm_pkg::mode_t'(mode);
			id_q    <= SW'(list_id);
			id_ok_q <= 32'(list_id) < LIST_SLOTS;
			val_q   <= WORD_BITS'(entry_value);
			size_q  <= entry_size;
		end
	end

	// Descriptor view after the update lands (done cycle).
	logic [CW-1:0] len_n;
	assign len_n = (id_ok_q && open_q[id_q]) ? cnt_q[id_q] : '0;
	assign list_length = 8'(len_n);
	assign occupied_count = 8'(used_q);
endmodule
`default_nettype wire
